### rtl/lcsc_pkg.sv
package lcsc_pkg;

  localparam int unsigned NumCh      = 3;
  localparam int unsigned FuncW      = 4;
  localparam int unsigned ChanW      = 2;
  localparam int unsigned PowerW     = 8;
  localparam int unsigned PulseW     = 20;
  localparam int unsigned OnTimeW    = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [PowerW-1:0]  DefaultPower      = 8'd255;
  localparam logic               RstInterlockEn    = 1'b1;
  localparam logic [PulseW-1:0]  RstPulseOnTime    = 20'd100;
  localparam logic [OnTimeW-1:0] RstMaxOnTime      = 32'd60000000;

  typedef enum logic [FuncW-1:0] {
    FnTick        = 4'd0,
    FnSetPower    = 4'd1,
    FnSetAllPower = 4'd2,
    FnEnable      = 4'd3,
    FnDisable     = 4'd4,
    FnEnableAll   = 4'd5,
    FnDisableAll  = 4'd6,
    FnPulse       = 4'd7,
    FnPulseAll    = 4'd8,
    FnEstop       = 4'd9
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInterlockEn = 2'd0,
    CfgPulseOnTime = 2'd1,
    CfgMaxOnTime   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [ChanW-1:0]  channel;
    logic [PowerW-1:0] power;
    logic              cartridge_present;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [NumCh-1:0]   laser_drive;
    logic [NumCh-1:0]   enabled_mask;
    logic [OnTimeW-1:0] on_time;
    logic               pulse_active;
    logic               overtime_trip;
  } rsp_t;

  typedef struct packed {
    logic               interlock_enable;
    logic [PulseW-1:0]  pulse_on_time;
    logic [OnTimeW-1:0] max_on_time;
  } cfg_t;

endpackage

### rtl/lcsc_if.sv
interface lcsc_req_if;
  logic            valid;
  logic            ready;
  lcsc_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcsc_rsp_if;
  logic            valid;
  logic            ready;
  lcsc_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/lcsc_cfg_regs.sv
module lcsc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lcsc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output lcsc_pkg::cfg_t                     cfg_o
);
  import lcsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgInterlockEn: cfg_d.interlock_enable = cfg_wdata_i[0];
        CfgPulseOnTime: cfg_d.pulse_on_time    = cfg_wdata_i[PulseW-1:0];
        CfgMaxOnTime:   cfg_d.max_on_time      = cfg_wdata_i[OnTimeW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interlock_enable <= RstInterlockEn;
      cfg_q.pulse_on_time    <= RstPulseOnTime;
      cfg_q.max_on_time      <= RstMaxOnTime;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/lcsc_core.sv
module lcsc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  lcsc_pkg::req_t  req_i,
  input  lcsc_pkg::cfg_t  cfg_i,
  output lcsc_pkg::rsp_t  rsp_o
);
  import lcsc_pkg::*;

  logic [PowerW-1:0]  power_q [NumCh];
  logic [PowerW-1:0]  power_d [NumCh];
  logic [NumCh-1:0]   en_q, en_d;
  logic [OnTimeW-1:0] cnt_q, cnt_d, cnt_tick;
  logic [NumCh-1:0]   pmask_q, pmask_d;
  logic [PulseW-1:0]  prem_q, prem_d;

  logic [NumCh-1:0]   ch_sel;
  logic [NumCh-1:0]   pw_nz, pw_nz_d;
  logic               ch_ok, safe, pulse_ok, ok, trip, is_tick;

  assign ch_ok    = req_i.channel < ChanW'(NumCh);
  assign safe     = !cfg_i.interlock_enable || req_i.cartridge_present;
  assign pulse_ok = (prem_q == '0) && safe;
  assign is_tick  = func_e'(req_i.func) == FnTick;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      ch_sel[i] = ch_ok && (req_i.channel == ChanW'(i));
      pw_nz[i]  = power_q[i] != '0;
    end
  end

  // on-time count while any channel stays on, saturating
  assign cnt_tick = ((|en_q) && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    power_d = power_q;
    en_d    = en_q;
    pmask_d = pmask_q;
    prem_d  = prem_q;
    ok      = 1'b0;
    trip    = 1'b0;
    unique case (func_e'(req_i.func))
      FnTick: begin
        ok = 1'b1;
        if (prem_q != '0) begin
          prem_d = prem_q - 1'b1;
          if (prem_q == PulseW'(1)) pmask_d = '0;
        end
        if (cfg_i.interlock_enable && !req_i.cartridge_present) en_d = '0;
        if ((|en_d) && (cnt_tick >= cfg_i.max_on_time)) begin
          en_d = '0;
          trip = 1'b1;
        end
      end
      FnSetPower: begin
        if (ch_ok) begin
          for (int i = 0; i < NumCh; i++) begin
            if (ch_sel[i]) begin
              power_d[i] = req_i.power;
              if (req_i.power == '0) en_d[i] = 1'b0;
            end
          end
          ok = 1'b1;
        end
      end
      FnSetAllPower: begin
        for (int i = 0; i < NumCh; i++) power_d[i] = req_i.power;
        if (req_i.power == '0) en_d = '0;
        ok = 1'b1;
      end
      FnEnable: begin
        if (safe && (|(ch_sel & pw_nz))) begin
          en_d = en_q | ch_sel;
          ok   = 1'b1;
        end
      end
      FnDisable: begin
        if (ch_ok) begin
          en_d = en_q & ~ch_sel;
          ok   = 1'b1;
        end
      end
      FnEnableAll: begin
        if (safe) begin
          en_d = en_q | pw_nz;
          ok   = &pw_nz;
        end
      end
      FnDisableAll: begin
        en_d = '0;
        ok   = 1'b1;
      end
      FnPulse: begin
        if (ch_ok && pulse_ok) begin
          ok = 1'b1;
          if (cfg_i.pulse_on_time != '0) begin
            pmask_d = ch_sel;
            prem_d  = cfg_i.pulse_on_time;
          end
        end
      end
      FnPulseAll: begin
        if (pulse_ok) begin
          ok = 1'b1;
          if (cfg_i.pulse_on_time != '0) begin
            pmask_d = '1;
            prem_d  = cfg_i.pulse_on_time;
          end
        end
      end
      FnEstop: begin
        en_d    = '0;
        pmask_d = '0;
        prem_d  = '0;
        ok      = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // count restarts when the first channel turns on and clears when the last turns off
  always_comb begin
    if (!(|en_d) || !(|en_q)) begin
      cnt_d = '0;
    end else if (is_tick) begin
      cnt_d = cnt_tick;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NumCh; i++) pw_nz_d[i] = power_d[i] != '0;
  end

  assign rsp_o.ok            = ok;
  assign rsp_o.laser_drive   = (en_d & pw_nz_d) | pmask_d;
  assign rsp_o.enabled_mask  = en_d;
  assign rsp_o.on_time       = cnt_d;
  assign rsp_o.pulse_active  = prem_d != '0;
  assign rsp_o.overtime_trip = trip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) power_q[i] <= DefaultPower;
      en_q    <= '0;
      cnt_q   <= '0;
      pmask_q <= '0;
      prem_q  <= '0;
    end else if (step_i) begin
      power_q <= power_d;
      en_q    <= en_d;
      cnt_q   <= cnt_d;
      pmask_q <= pmask_d;
      prem_q  <= prem_d;
    end
  end

endmodule

### rtl/laser_channel_safety_controller.sv
// laser channel safety controller
// req_i carries one request per item: a command (set power, enable, disable,
// pulse, emergency stop) or a one microsecond tick, each with a sample of
// the cartridge switch. rsp_o returns exactly one result per request: ok,
// the laser drive pins, the enable mask, the on-time count, the pulse flag
// and the overtime trip flag, all as they stand after that request.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write interlock_enable (0), pulse_on_time
// (1) and max_on_time (2); write them only while no request is in flight.
// a request waits in the input register until the output register is free,
// the channel state is updated from it in a single pass, and the result is
// registered: rsp_o.valid rises when the result enters the output register.
// one request per cycle is sustained while the receiver takes every result;
// the state update loop through the channel registers sets that figure.
// reset clears all channel enables, the on-time count and any pulse, sets
// every channel to full power and loads the register defaults.
// when the receiver stalls, the result holds in the output register and one
// more request is still taken into the input register before req_i.ready
// falls.
module laser_channel_safety_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lcsc_req_if.sink                       req_i,
  lcsc_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [lcsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lcsc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import lcsc_pkg::*;

  cfg_t cfg;
  logic in_valid_q;
  req_t in_data_q;
  logic out_valid_q;
  rsp_t out_data_q;
  rsp_t core_rsp;
  logic out_free, step;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign step        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;

  lcsc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_data_q),
    .cfg_i  (cfg),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) in_valid_q <= req_i.valid;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) in_data_q <= req_i.data;
    if (step) out_data_q <= core_rsp;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

endmodule

### rtl/lcsc_checker.sv
module lcsc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input lcsc_pkg::rsp_t  rsp_data_i
);
  import lcsc_pkg::*;

  // an overtime trip leaves every channel off with the count cleared
  a_trip_all_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.overtime_trip |->
      (rsp_data_i.enabled_mask == '0) && (rsp_data_i.on_time == '0) && rsp_data_i.ok)
    else $error("overtime trip with channels still enabled");

  a_off_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.enabled_mask == '0) |-> (rsp_data_i.on_time == '0))
    else $error("on-time count nonzero with no channel enabled");

  // a driven pin that is not enabled can only come from a running pulse
  a_drive_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((rsp_data_i.laser_drive & ~rsp_data_i.enabled_mask) != '0) |->
      rsp_data_i.pulse_active)
    else $error("laser drive without enable or pulse");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled result changed");

endmodule

bind laser_channel_safety_controller lcsc_checker u_lcsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

### sim/laser_channel_safety_controller_tb.sv
import lcsc_pkg::*;

class laser_status_board;
  logic              interlock_en;
  logic [PulseW-1:0] pulse_len;
  logic [OnTimeW-1:0] max_on;

  logic [PowerW-1:0]  power [NumCh];
  logic [NumCh-1:0]   enabled;
  bit                 any_was_on;
  logic [OnTimeW-1:0] on_count;
  logic [NumCh-1:0]   pulse_mask;
  logic [PulseW-1:0]  pulse_left;

  rsp_t        expected_status_q[$];
  int unsigned errors;

  function new();
    int i;
    interlock_en = RstInterlockEn;
    pulse_len    = RstPulseOnTime;
    max_on       = RstMaxOnTime;
    for (i = 0; i < NumCh; i++) power[i] = DefaultPower;
    enabled    = '0;
    any_was_on = 1'b0;
    on_count   = '0;
    pulse_mask = '0;
    pulse_left = '0;
    errors     = 0;
  endfunction

  function void set_limits(logic il, logic [PulseW-1:0] pot, logic [OnTimeW-1:0] mot);
    interlock_en = il;
    pulse_len    = pot;
    max_on       = mot;
  endfunction

  function int unsigned pending();
    return expected_status_q.size();
  endfunction

  // on-time restarts when the first channel comes on and clears when the last goes off
  function void track_on();
    bit on;
    on = |enabled;
    if (on != any_was_on) on_count = '0;
    any_was_on = on;
  endfunction

  function void all_off();
    enabled = '0;
    track_on();
  endfunction

  function bit interlock_ok(logic cart);
    return !interlock_en || cart;
  endfunction

  function bit try_pulse(logic [NumCh-1:0] m, logic cart);
    if (pulse_left != '0) return 1'b0;
    if (!interlock_ok(cart)) return 1'b0;
    // a zero pulse length is accepted but times nothing
    if (pulse_len != '0) begin
      pulse_mask = m;
      pulse_left = pulse_len;
    end
    return 1'b1;
  endfunction

  function void take_request(req_t r);
    rsp_t        want;
    bit          ok;
    bit          trip;
    bit          ch_ok;
    int unsigned c;
    int          i;
    ok    = 1'b0;
    trip  = 1'b0;
    ch_ok = r.channel < NumCh;
    c     = r.channel;
    case (r.func)
      FnTick: begin
        ok = 1'b1;
        if (pulse_left != '0) begin
          pulse_left--;
          if (pulse_left == '0) pulse_mask = '0;
        end
        if (any_was_on && on_count != '1) on_count++;
        if (interlock_en && !r.cartridge_present && |enabled) all_off();
        if (any_was_on && on_count >= max_on) begin
          all_off();
          trip = 1'b1;
        end
      end
      FnSetPower: begin
        if (ch_ok) begin
          power[c] = r.power;
          if (r.power == '0 && enabled[c]) begin
            enabled[c] = 1'b0;
            track_on();
          end
          ok = 1'b1;
        end
      end
      FnSetAllPower: begin
        for (i = 0; i < NumCh; i++) power[i] = r.power;
        if (r.power == '0) all_off();
        ok = 1'b1;
      end
      FnEnable: begin
        if (ch_ok && interlock_ok(r.cartridge_present) && power[c] != '0) begin
          enabled[c] = 1'b1;
          track_on();
          ok = 1'b1;
        end
      end
      FnDisable: begin
        if (ch_ok) begin
          enabled[c] = 1'b0;
          track_on();
          ok = 1'b1;
        end
      end
      FnEnableAll: begin
        if (interlock_ok(r.cartridge_present)) begin
          ok = 1'b1;
          for (i = 0; i < NumCh; i++) begin
            if (power[i] != '0) enabled[i] = 1'b1;
            else ok = 1'b0;
          end
          track_on();
        end
      end
      FnDisableAll: begin
        all_off();
        ok = 1'b1;
      end
      FnPulse: begin
        if (ch_ok) ok = try_pulse(NumCh'(1) << c, r.cartridge_present);
      end
      FnPulseAll: begin
        ok = try_pulse('1, r.cartridge_present);
      end
      FnEstop: begin
        enabled    = '0;
        on_count   = '0;
        any_was_on = 1'b0;
        pulse_mask = '0;
        pulse_left = '0;
        ok         = 1'b1;
      end
      default: begin
      end
    endcase

    want.ok           = ok;
    want.enabled_mask = enabled;
    for (i = 0; i < NumCh; i++) want.laser_drive[i] = enabled[i] && power[i] != '0;
    want.laser_drive   = want.laser_drive | pulse_mask;
    want.on_time       = any_was_on ? on_count : '0;
    want.pulse_active  = pulse_left != '0;
    want.overtime_trip = trip;
    expected_status_q.push_back(want);
  endfunction

  function void check_status(rsp_t got);
    rsp_t want;
    if (expected_status_q.size() == 0) begin
      $error("result with no request waiting: %h", got);
      errors++;
      return;
    end
    want = expected_status_q.pop_front();
    if (got.ok !== want.ok) begin
      $error("ok: expected %0d, got %0d", want.ok, got.ok);
      errors++;
    end
    if (got.laser_drive !== want.laser_drive) begin
      $error("laser_drive: expected %b, got %b", want.laser_drive, got.laser_drive);
      errors++;
    end
    if (got.enabled_mask !== want.enabled_mask) begin
      $error("enabled_mask: expected %b, got %b", want.enabled_mask, got.enabled_mask);
      errors++;
    end
    if (got.on_time !== want.on_time) begin
      $error("on_time: expected %0d, got %0d", want.on_time, got.on_time);
      errors++;
    end
    if (got.pulse_active !== want.pulse_active) begin
      $error("pulse_active: expected %0d, got %0d", want.pulse_active, got.pulse_active);
      errors++;
    end
    if (got.overtime_trip !== want.overtime_trip) begin
      $error("overtime_trip: expected %0d, got %0d", want.overtime_trip, got.overtime_trip);
      errors++;
    end
  endfunction
endclass

module laser_channel_safety_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned FuncUnusedLo = int'(FnEstop) + 1;
  localparam int unsigned FuncUnusedHi = (1 << FuncW) - 1;
  localparam int unsigned BadChannel   = NumCh;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  bit req_gaps;
  bit rsp_stalls;
  bit hold_off;
  int unsigned cycles;

  laser_status_board board;

  lcsc_req_if req_if();
  lcsc_rsp_if rsp_if();

  laser_channel_safety_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) board.check_status(rsp_if.data);
  end

  // receiver: random short stalls, or one long hold so the block backs up
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_off) begin
        hold_off   = 1'b0;
        stall_left = HoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("laser_channel_safety_controller_tb: FAIL");
    $finish;
  end

  function automatic req_t make_req(logic [FuncW-1:0] f, int unsigned ch, int unsigned pw,
                                    logic cart);
    req_t r;
    r.func              = f;
    r.channel           = ChanW'(ch);
    r.power             = PowerW'(pw);
    r.cartridge_present = cart;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35)      r.func = FnTick;
    else if (roll < 43) r.func = FnSetPower;
    else if (roll < 47) r.func = FnSetAllPower;
    else if (roll < 62) r.func = FnEnable;
    else if (roll < 69) r.func = FnDisable;
    else if (roll < 75) r.func = FnEnableAll;
    else if (roll < 78) r.func = FnDisableAll;
    else if (roll < 86) r.func = FnPulse;
    else if (roll < 91) r.func = FnPulseAll;
    else if (roll < 94) r.func = FnEstop;
    else                r.func = FuncW'($urandom_range(FuncUnusedLo, FuncUnusedHi));
    r.channel = ($urandom_range(0, 9) == 0) ? ChanW'(BadChannel)
                                            : ChanW'($urandom_range(0, NumCh - 1));
    r.power   = ($urandom_range(0, 6) == 0) ? '0 : PowerW'($urandom_range(0, 255));
    r.cartridge_present = $urandom_range(0, 9) != 0;
    return r;
  endfunction

  // called at a clock edge; returns at the edge where the request was taken
  task automatic send_request(req_t r);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.take_request(r);
  endtask

  task automatic await_idle();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_settings(logic il, logic [PulseW-1:0] pot, logic [OnTimeW-1:0] mot);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgInterlockEn;
    cfg_wdata <= CfgDataW'(il);
    @(posedge clk_i);
    cfg_idx   <= CfgPulseOnTime;
    cfg_wdata <= CfgDataW'(pot);
    @(posedge clk_i);
    cfg_idx   <= CfgMaxOnTime;
    cfg_wdata <= mot;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_limits(il, pot, mot);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if (req_gaps && $urandom_range(0, 6) == 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      send_request(random_request());
    end
  endtask

  initial begin
    board        = new();
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgInterlockEn;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    req_gaps     = 1'b0;
    rsp_stalls   = 1'b1;
    hold_off     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests at the reset settings
    send_request(make_req(FnTick, 0, 0, 1'b1));
    send_request(make_req(FnEnable, BadChannel, 0, 1'b1));
    send_request(make_req(FnEnable, 0, 0, 1'b0));
    send_request(make_req(FnEnable, 0, 0, 1'b1));
    send_request(make_req(FnTick, 1, 255, 1'b1));
    send_request(make_req(FnSetPower, 0, 0, 1'b1));
    send_request(make_req(FnSetPower, BadChannel, 255, 1'b1));
    send_request(make_req(FnSetAllPower, 0, 255, 1'b1));
    send_request(make_req(FnEnableAll, 0, 0, 1'b1));
    send_request(make_req(FnSetPower, 1, 0, 1'b1));
    send_request(make_req(FnDisableAll, 0, 0, 1'b1));
    send_request(make_req(FnEnableAll, 0, 0, 1'b1));
    send_request(make_req(FnTick, 0, 0, 1'b0));
    send_request(make_req(FnPulse, 2, 0, 1'b1));
    send_request(make_req(FnPulseAll, 0, 0, 1'b1));
    send_request(make_req(FnTick, 2, 0, 1'b1));
    send_request(make_req(FnDisable, 2, 0, 1'b1));
    send_request(make_req(FnPulse, BadChannel, 0, 1'b1));
    send_request(make_req(FnEstop, 0, 0, 1'b1));
    send_request(make_req(FuncW'(FuncUnusedHi), 3, 255, 1'b1));
    send_request(make_req(FuncW'(FuncUnusedLo), 0, 0, 1'b0));
    send_request(make_req(FnDisable, BadChannel, 0, 1'b1));
    send_request(make_req(FnPulseAll, 0, 0, 1'b0));
    send_request(make_req(FnSetPower, 2, 'hAA, 1'b1));

    // interlock off, zero pulse length, zero on-time limit
    write_settings(1'b0, '0, '0);
    send_request(make_req(FnEnable, 0, 0, 1'b0));
    send_request(make_req(FnTick, 0, 0, 1'b0));
    send_request(make_req(FnPulseAll, 0, 0, 1'b0));
    send_request(make_req(FnPulse, 1, 0, 1'b0));

    req_gaps = 1'b1;
    write_settings(1'b1, 20'd5, 32'd30);
    run_random(PhaseItems);
    write_settings(1'b0, 20'd1, 32'd12);
    run_random(PhaseItems);
    write_settings(1'b1, '1, '1);
    run_random(PhaseItems);
    write_settings(1'b0, '0, '0);
    run_random(PhaseItems);
    write_settings(1'b1, PulseW'($urandom_range(1, 20)), OnTimeW'($urandom_range(1, 60)));
    hold_off = 1'b1;
    run_random(PhaseItems);
    write_settings(RstInterlockEn, RstPulseOnTime, RstMaxOnTime);
    run_random(PhaseItems);

    // closing stretch runs flat out on both sides
    req_gaps   = 1'b0;
    rsp_stalls = 1'b0;
    write_settings(1'b0, PulseW'($urandom_range(2, 8)), OnTimeW'($urandom_range(5, 25)));
    run_random(PhaseItems);

    await_idle();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("laser_channel_safety_controller_tb: PASS");
    end else begin
      $display("laser_channel_safety_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
